>>> src/pm_sensor_frame_averager_defines.svh
// assertion macros shared by the frame averager rtl
`ifndef PM_SENSOR_FRAME_AVERAGER_DEFINES_SVH
`define PM_SENSOR_FRAME_AVERAGER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PMSFA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pmsfa assertion failed");

// next-cycle implication, checked outside reset
`define PMSFA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pmsfa assertion failed");

`endif

>>> src/pmsfa_pkg.sv
package pmsfa_pkg;

   // default sizes
   localparam int unsigned DEF_BUFFER_BYTES = 64;
   localparam int unsigned DEF_FRAME_BYTES  = 20;
   localparam int unsigned DEF_WINDOW_SIZE  = 5;

   // only bytes 0..6 of a frame are needed (header and pm2.5 field)
   localparam int unsigned KEPT_BYTES = 7;
   localparam int unsigned PM_HI_POS  = 5;
   localparam int unsigned PM_LO_POS  = 6;

   // expected header
   localparam logic [7:0] HEADER_0 = 8'h16;
   localparam logic [7:0] HEADER_1 = 8'h11;
   localparam logic [7:0] HEADER_2 = 8'h0B;

   typedef enum logic [1:0] {
      STATUS_NONE       = 2'd0,
      STATUS_ACCEPT     = 2'd1,
      STATUS_BAD_HEADER = 2'd2,
      STATUS_BAD_SUM    = 2'd3
   } frame_status_type;

   // one result beat
   typedef struct packed {
      frame_status_type frame_status;
      logic [15:0]      pm25_reading;
      logic             average_new;
      logic [15:0]      average_value;
      logic             average_valid;
   } result_type;

endpackage

>>> src/pm_sensor_frame_averager.sv
// each accepted beat's result is registered into the rsp_* result register, or into the skid register
// throughput: one byte per cycle while req_stall is low; checksum and window sum are kept as running sums
// output: result register plus one skid register, so req_stall only rises when both are full
// reset: synchronous, clears byte buffer, count, checksum, window, average and both output valid flags;
// the first average appears after WINDOW_SIZE accepted frames
`include "pm_sensor_frame_averager_defines.svh"

module pm_sensor_frame_averager
   import pmsfa_pkg::*;
#(
   parameter int unsigned BUFFER_BYTES = DEF_BUFFER_BYTES,
   parameter int unsigned FRAME_BYTES  = DEF_FRAME_BYTES,
   parameter int unsigned WINDOW_SIZE  = DEF_WINDOW_SIZE
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_burst_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_frame_status,
   output logic [15:0] rsp_pm25_reading,
   output logic        rsp_average_new,
   output logic [15:0] rsp_average_value,
   output logic        rsp_average_valid
);

   localparam int unsigned CNT_W   = $clog2(BUFFER_BYTES);
   localparam int unsigned IDX_W   = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
   localparam int unsigned SUM_W   = 16 + $clog2(WINDOW_SIZE);
   // floor(n / WINDOW_SIZE) as (n * RECIP) >> SHIFT, exact for n below 2**SUM_W
   localparam int unsigned SHIFT   = SUM_W + $clog2(WINDOW_SIZE);
   localparam int unsigned RECIP_W = SHIFT + 1;
   localparam longint unsigned RECIP = ((64'd1 << SHIFT) + WINDOW_SIZE - 1) / WINDOW_SIZE;
   localparam int unsigned PROD_W  = SUM_W + RECIP_W;

   logic [CNT_W-1:0] cnt_ff,  cnt_in;
   logic [7:0]       kept_ff [KEPT_BYTES];
   logic [7:0]       kept_in [KEPT_BYTES];
   logic [7:0]       csum_ff, csum_in;
   logic [IDX_W-1:0] idx_ff,  idx_in;
   logic [SUM_W-1:0] acc_ff,  acc_in;
   logic [15:0]      avg_ff,  avg_in;
   logic             seen_ff, seen_in;

   logic             out_valid_ff, out_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   result_type       out_ff, out_in;
   result_type       skid_ff, skid_in;
   result_type       res;

   logic [7:0]       stored [KEPT_BYTES];
   logic [7:0]       csum_add;
   logic             buf_full;
   logic             header_ok;
   logic [15:0]      pm;
   logic [SUM_W-1:0] win_sum;
   logic [PROD_W-1:0] prod;
   logic             accept_in;
   logic             out_free;

   assign req_stall = skid_valid_ff;
   assign accept_in = req_valid & ~req_stall;
   assign out_free  = ~out_valid_ff | ~rsp_stall;

   // store the byte, run the checksum, clear on a full buffer
   always_comb begin
      buf_full = (cnt_ff == CNT_W'(BUFFER_BYTES - 1));
      for (int i = 0; i < KEPT_BYTES; i++) begin
         stored[i] = (32'(cnt_ff) == i) ? req_rx_byte : kept_ff[i];
         if (buf_full) begin
            stored[i] = 8'd0;
         end
      end
      csum_add = (32'(cnt_ff) < FRAME_BYTES) ? (csum_ff + req_rx_byte) : csum_ff;
      if (buf_full) begin
         csum_add = 8'd0;
      end
   end

   // frame check and window sum
   always_comb begin
      header_ok = (stored[0] == HEADER_0) && (stored[1] == HEADER_1) &&
                  (stored[2] == HEADER_2);
      pm        = {stored[PM_HI_POS], stored[PM_LO_POS]};
      win_sum   = acc_ff + SUM_W'(pm);
      prod      = PROD_W'(win_sum) * PROD_W'(RECIP);
   end

   // next state and result
   always_comb begin
      cnt_in  = buf_full ? '0 : (cnt_ff + 1'b1);
      kept_in = stored;
      csum_in = csum_add;
      idx_in  = idx_ff;
      acc_in  = acc_ff;
      avg_in  = avg_ff;
      seen_in = seen_ff;
      res.frame_status = STATUS_NONE;
      res.pm25_reading = 16'd0;
      res.average_new  = 1'b0;
      if (req_burst_end) begin
         if (!header_ok) begin
            res.frame_status = STATUS_BAD_HEADER;
         end else if (csum_add != 8'd0) begin
            res.frame_status = STATUS_BAD_SUM;
         end else begin
            res.frame_status = STATUS_ACCEPT;
            res.pm25_reading = pm;
            if (idx_ff == IDX_W'(WINDOW_SIZE - 1)) begin
               idx_in  = '0;
               acc_in  = '0;
               avg_in  = prod[SHIFT +: 16];
               seen_in = 1'b1;
               res.average_new = 1'b1;
            end else begin
               idx_in = idx_ff + 1'b1;
               acc_in = win_sum;
            end
         end
         cnt_in  = '0;
         csum_in = 8'd0;
         for (int i = 0; i < KEPT_BYTES; i++) begin
            kept_in[i] = 8'd0;
         end
      end
      res.average_value = avg_in;
      res.average_valid = seen_in;
   end

   // frame and window state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         csum_ff <= 8'd0;
         idx_ff  <= '0;
         acc_ff  <= '0;
         avg_ff  <= 16'd0;
         seen_ff <= 1'b0;
         for (int i = 0; i < KEPT_BYTES; i++) begin
            kept_ff[i] <= 8'd0;
         end
      end else if (accept_in) begin
         cnt_ff  <= cnt_in;
         csum_ff <= csum_in;
         idx_ff  <= idx_in;
         acc_ff  <= acc_in;
         avg_ff  <= avg_in;
         seen_ff <= seen_in;
         kept_ff <= kept_in;
      end
   end

   // result register with skid stage
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = res;
            out_valid_in = accept_in;
         end
      end else if (accept_in) begin
         skid_in       = res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_frame_status  = out_ff.frame_status;
   assign rsp_pm25_reading  = out_ff.pm25_reading;
   assign rsp_average_new   = out_ff.average_new;
   assign rsp_average_value = out_ff.average_value;
   assign rsp_average_valid = out_ff.average_valid;

   // checks
   `PMSFA_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `PMSFA_ASSERT_NOW(a_new_avg_on_accept, clock, reset, out_valid_ff && out_ff.average_new, (out_ff.frame_status == STATUS_ACCEPT) && out_ff.average_valid)
   `PMSFA_ASSERT_NOW(a_pm_zero_unless_ok, clock, reset, out_valid_ff && (out_ff.frame_status != STATUS_ACCEPT), out_ff.pm25_reading == 16'd0)
   `PMSFA_ASSERT_NEXT(a_burst_clears, clock, reset, accept_in && req_burst_end, (cnt_ff == '0) && (csum_ff == 8'd0))
   `PMSFA_ASSERT_NOW(a_idx_in_window, clock, reset, 1'b1, 32'(idx_ff) < WINDOW_SIZE)

endmodule
